// ===== rtl/slfr_pkg.sv =====
package slfr_pkg;

	localparam int WORD_W     = 32;
	localparam int LONG_LAG   = 55;
	localparam int SHORT_LAG  = 24;
	localparam int LAG_SHORT  = (SHORT_LAG < LONG_LAG) ? SHORT_LAG : (LONG_LAG - 1);
	localparam int TAP_POS    = LONG_LAG - LAG_SHORT;
	localparam int POS_W      = $clog2(LONG_LAG);
	localparam int FILL_STEP  = 21 % LONG_LAG;
	localparam int WARM_STEPS = LONG_LAG * LONG_LAG;
	localparam int WARM_W     = $clog2(WARM_STEPS);
	localparam int DIV_STEPS  = WORD_W + 1;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [POS_W-1:0]  pos_t;

	localparam word_t SEED_RESET   = 32'd1003156459;
	localparam word_t START_FRAC   = 32'd3139621093;
	localparam word_t SMALL_FRAC   = 32'd738734375;
	localparam word_t SEED_MIN     = 32'h8000_0000;
	localparam word_t SEED_MIN_MAG = 32'h7FFF_FFFF;

	typedef enum logic {
		OP_DRAW    = 1'b0,
		OP_RESTART = 1'b1
	} slfr_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_DIV,
		ST_FILL,
		ST_ALIGN,
		ST_WARM,
		ST_DONE
	} slfr_state_t;

	typedef struct packed {
		logic shift;
		logic clear;
	} slfr_chain_ctl_t;

endpackage

// ===== rtl/slfr_cell.sv =====
module slfr_cell (
	input  logic                     clk,
	input  slfr_pkg::slfr_chain_ctl_t ctl,
	input  slfr_pkg::word_t          d,
	output slfr_pkg::word_t          q
);
	import slfr_pkg::*;

	word_t val_q;

	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			val_q <= '0;
		end else if (ctl.shift) begin
			val_q <= d;
		end
	end

	assign q = val_q;

endmodule

// ===== rtl/slfr_chain.sv =====
module slfr_chain (
	input  logic                     clk,
	input  slfr_pkg::slfr_chain_ctl_t ctl,
	input  slfr_pkg::word_t          feed,
	output slfr_pkg::word_t          head,
	output slfr_pkg::word_t          tap
);
	import slfr_pkg::*;

	word_t val [LONG_LAG];

	for (genvar k = 0; k < LONG_LAG; k++) begin : g_cell
		if (k == LONG_LAG - 1) begin : g_last
			slfr_cell u_cell (
				.clk (clk),
				.ctl (ctl),
				.d   (feed),
				.q   (val[k])
			);
		end else begin : g_mid
			slfr_cell u_cell (
				.clk (clk),
				.ctl (ctl),
				.d   (val[k+1]),
				.q   (val[k])
			);
		end
	end

	assign head = val[0];
	assign tap  = val[TAP_POS];

endmodule

// ===== rtl/slfr_recip.sv =====
module slfr_recip (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  slfr_pkg::word_t magnitude,
	output logic            done,
	output slfr_pkg::word_t recip
);
	import slfr_pkg::*;

	logic                 run_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	word_t                rem_q;
	word_t                quo_q;
	word_t                div_q;
	logic [WORD_W:0]      trial;
	logic                 fits;
	logic                 last;

	assign trial = {rem_q, (cnt_q == '0)};
	assign fits  = trial >= {1'b0, div_q};
	assign last  = cnt_q == DIV_CNT_W'(DIV_STEPS - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= run_q && last;
			if (start) begin
				run_q <= 1'b1;
			end else if (run_q && last) begin
				run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= '0;
			div_q <= magnitude;
			cnt_q <= '0;
		end else if (run_q) begin
			rem_q <= fits ? WORD_W'(trial - {1'b0, div_q}) : trial[WORD_W-1:0];
			quo_q <= {quo_q[WORD_W-2:0], fits};
			cnt_q <= cnt_q + 1'b1;
		end
	end

	assign done  = done_q;
	assign recip = (div_q > word_t'(1)) ? quo_q : SMALL_FRAC;

endmodule

// ===== rtl/subtractive_lagged_fibonacci_rng_unit.sv =====
// channel  | valid        | stall        | word
// ---------+--------------+--------------+-------------------------------
// item     | item_valid   | item_stall   | opcode, range_limit
// result   | result_valid | result_stall | fraction, picked, restarted
// seed     | seed_write   | -            | seed_value
//
// A draw waits in the item register until the result register is free; its
// result word is then registered, and draws stream back to back while the
// result is not stalled. A restart runs these steps after the cycle that
// decodes it: clear, bit-serial reciprocal, rotating table fill, realign,
// warm-up (55 x 55 shifts of the 55-cell row, one per cycle), acknowledge.
// Reset runs the same restart from the reset seed, with no acknowledge; an
// item may be taken into the item register meanwhile and waits there. A stalled
// result holds while one more item is taken.
module subtractive_lagged_fibonacci_rng_unit (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   seed_write,
	input  logic signed [31:0]     seed_value,
	input  logic                   item_valid,
	output logic                   item_stall,
	input  logic                   opcode,
	input  logic [31:0]            range_limit,
	output logic                   result_valid,
	input  logic                   result_stall,
	output logic [31:0]            fraction,
	output logic [31:0]            picked,
	output logic                   restarted
);
	import slfr_pkg::*;

	slfr_state_t     state_q, state_d;
	slfr_chain_ctl_t chain_ctl;
	logic            ack_q;
	logic            item_valid_q;
	slfr_op_t        item_op_q;
	word_t           item_limit_q;
	logic            out_valid_q;
	word_t           fraction_q;
	word_t           picked_q;
	logic            restarted_q;
	logic signed [31:0] seed_q;

	word_t           magnitude;
	word_t           recip;
	logic            recip_done;
	logic            recip_start;
	word_t           head;
	word_t           tap;
	word_t           feed;
	logic [63:0]     prod;

	pos_t            pos_q;
	pos_t            target_q;
	pos_t            fill_cnt_q;
	logic [WARM_W-1:0] warm_q;
	word_t           fill_a_q;
	word_t           fill_b_q;
	logic [POS_W:0]  target_sum;
	pos_t            target_next;
	pos_t            pos_next;
	logic            fill_hit;

	logic            out_free;
	logic            accept;
	logic            item_done;
	logic            emit_draw;
	logic            emit_restart;
	logic            limit_one;

	assign magnitude = (seed_q == signed'(SEED_MIN)) ? SEED_MIN_MAG :
	                   seed_q[31] ? unsigned'(-seed_q) : unsigned'(seed_q);

	assign target_sum  = {1'b0, target_q} + (POS_W+1)'(FILL_STEP);
	assign target_next = (target_sum >= (POS_W+1)'(LONG_LAG)) ?
	                     POS_W'(target_sum - (POS_W+1)'(LONG_LAG)) : target_sum[POS_W-1:0];
	assign pos_next    = (pos_q == POS_W'(LONG_LAG - 1)) ? '0 : pos_q + 1'b1;
	assign fill_hit    = pos_q == target_q;

	assign out_free  = !out_valid_q || !result_stall;
	assign limit_one = item_limit_q == word_t'(1);
	assign prod      = {32'd0, head} * {32'd0, item_limit_q};

	slfr_recip u_recip (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (recip_start),
		.magnitude (magnitude),
		.done      (recip_done),
		.recip     (recip)
	);

	slfr_chain u_chain (
		.clk  (clk),
		.ctl  (chain_ctl),
		.feed (feed),
		.head (head),
		.tap  (tap)
	);

	always_comb begin
		state_d      = state_q;
		chain_ctl    = '0;
		feed         = head;
		recip_start  = 1'b0;
		emit_draw    = 1'b0;
		emit_restart = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid_q) begin
					if (item_op_q == OP_RESTART) begin
						state_d = ST_CLEAR;
					end else if (out_free) begin
						emit_draw       = 1'b1;
						chain_ctl.shift = !limit_one;
						feed            = head - tap;
					end
				end
			end
			ST_CLEAR: begin
				chain_ctl.clear = 1'b1;
				recip_start     = 1'b1;
				state_d         = ST_DIV;
			end
			ST_DIV: begin
				if (recip_done) begin
					state_d = ST_FILL;
				end
			end
			ST_FILL: begin
				chain_ctl.shift = 1'b1;
				feed            = fill_hit ? fill_a_q : head;
				if (fill_hit && fill_cnt_q == POS_W'(LONG_LAG - 1)) begin
					state_d = ST_ALIGN;
				end
			end
			ST_ALIGN: begin
				if (pos_q == '0) begin
					state_d = ST_WARM;
				end else begin
					chain_ctl.shift = 1'b1;
				end
			end
			ST_WARM: begin
				chain_ctl.shift = 1'b1;
				feed            = head - tap;
				if (warm_q == WARM_W'(WARM_STEPS - 1)) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!ack_q) begin
					state_d = ST_IDLE;
				end else if (out_free) begin
					emit_restart = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign item_done  = emit_draw || emit_restart;
	assign item_stall = item_valid_q && !item_done;
	assign accept     = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			ack_q        <= 1'b0;
			item_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
			seed_q       <= signed'(SEED_RESET);
		end else begin
			state_q <= state_d;
			if (seed_write) begin
				seed_q <= seed_value;
			end
			if (state_q == ST_IDLE && item_valid_q && item_op_q == OP_RESTART) begin
				ack_q <= 1'b1;
			end else if (emit_restart) begin
				ack_q <= 1'b0;
			end
			if (accept) begin
				item_valid_q <= 1'b1;
			end else if (item_done) begin
				item_valid_q <= 1'b0;
			end
			if (item_done) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_op_q    <= slfr_op_t'(opcode);
			item_limit_q <= range_limit;
		end
		if (emit_draw) begin
			fraction_q  <= limit_one ? '0 : head;
			picked_q    <= limit_one ? '0 : prod[63:32];
			restarted_q <= 1'b0;
		end else if (emit_restart) begin
			fraction_q  <= '0;
			picked_q    <= '0;
			restarted_q <= 1'b1;
		end
		unique case (state_q)
			ST_DIV: begin
				fill_a_q   <= recip;
				fill_b_q   <= START_FRAC;
				fill_cnt_q <= '0;
				target_q   <= '0;
				pos_q      <= '0;
			end
			ST_FILL: begin
				pos_q <= pos_next;
				if (fill_hit) begin
					fill_a_q   <= fill_b_q - fill_a_q;
					fill_b_q   <= fill_a_q;
					target_q   <= target_next;
					fill_cnt_q <= fill_cnt_q + 1'b1;
				end
				warm_q <= '0;
			end
			ST_ALIGN: begin
				if (pos_q != '0) begin
					pos_q <= pos_next;
				end
				warm_q <= '0;
			end
			ST_WARM: begin
				warm_q <= warm_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign result_valid = out_valid_q;
	assign fraction     = fraction_q;
	assign picked       = picked_q;
	assign restarted    = restarted_q;

endmodule

// ===== rtl/slfr_checker.sv =====
module slfr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        result_valid,
	input logic        result_stall,
	input logic [31:0] fraction,
	input logic [31:0] picked,
	input logic        restarted
);

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(fraction) &&
		$stable(picked) && $stable(restarted))
		else $error("stalled result word changed");

	a_restart_word: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && restarted |-> fraction == 32'd0 && picked == 32'd0)
		else $error("restart acknowledge carries data");

	a_zero_scale: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && fraction == 32'd0 |-> picked == 32'd0)
		else $error("picked index from zero fraction");

	a_restart_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && restarted && !result_stall |=> !(result_valid && restarted))
		else $error("restart acknowledged twice in a row");

endmodule

bind subtractive_lagged_fibonacci_rng_unit slfr_checker u_checker (.*);

// ===== dv/subtractive_lagged_fibonacci_rng_unit_test.sv =====
`timescale 1ns / 1ps

module subtractive_lagged_fibonacci_rng_unit_test;
	import slfr_pkg::*;

	localparam int    ROW_LEN     = 55;
	localparam int    TAP_LAG     = 24;
	localparam int    TAP         = (TAP_LAG < ROW_LEN) ? TAP_LAG : (ROW_LEN - 1);
	localparam int    FILL_STRIDE = 21;
	localparam word_t START_Q32   = 32'd3139621093;
	localparam word_t SMALL_Q32   = 32'd738734375;
	localparam word_t MIN_SEED    = 32'h8000_0000;
	localparam word_t MIN_MAG     = 32'h7FFF_FFFF;
	localparam word_t BOOT_SEED   = 32'd1003156459;

	typedef struct packed {
		word_t fraction;
		word_t picked;
		logic  restarted;
	} draw_word_t;

	class draw_ledger;
		word_t       row [ROW_LEN];
		int unsigned rd_pos;
		word_t       seed_frac;
		word_t       seed_word;
		draw_word_t  awaited_draws [$];
		int unsigned errors;

		function new();
			errors = 0;
			seed_word = BOOT_SEED;
			reseed();
		endfunction

		function void load_seed(word_t v);
			seed_word = v;
		endfunction

		function int pending();
			return awaited_draws.size();
		endfunction

		function void regenerate();
			for (int i = 0; i < TAP; i++)
				row[i] = row[i] - row[i + ROW_LEN - TAP];
			for (int i = TAP; i < ROW_LEN; i++)
				row[i] = row[i] - row[i - TAP];
			rd_pos = 0;
		endfunction

		function void reseed();
			word_t       mag;
			word_t       a;
			word_t       b;
			logic [63:0] quot;
			int unsigned j;
			if (seed_word == MIN_SEED)
				mag = MIN_MAG;
			else if (seed_word[31])
				mag = -seed_word;
			else
				mag = seed_word;
			quot = (64'd1 << 32) / {32'd0, mag};
			seed_frac = (mag > 1) ? quot[31:0] : SMALL_Q32;
			foreach (row[k])
				row[k] = '0;
			a = seed_frac;
			b = START_Q32;
			for (int i = 0; i < ROW_LEN; i++) begin
				j = (FILL_STRIDE * i) % ROW_LEN;
				row[j] = a;
				a = b - a;
				b = row[j];
			end
			repeat (ROW_LEN) regenerate();
			rd_pos = 0;
		endfunction

		function void take_word(slfr_op_t op, word_t n);
			draw_word_t  r;
			logic [63:0] prod;
			r = '0;
			if (op == OP_RESTART) begin
				reseed();
				r.restarted = 1'b1;
			end else if (n != 32'd1) begin
				if (rd_pos >= ROW_LEN)
					regenerate();
				r.fraction = row[rd_pos];
				rd_pos++;
				prod = {32'd0, r.fraction} * {32'd0, n};
				r.picked = prod[63:32];
			end
			awaited_draws.push_back(r);
		endfunction

		function void match_word(word_t f, word_t p, logic r);
			draw_word_t e;
			if (awaited_draws.size() == 0) begin
				$display("%0t: unexpected word, expected none, actual %h %h %b", $time, f, p, r);
				errors++;
				return;
			end
			e = awaited_draws.pop_front();
			if (f !== e.fraction) begin
				$display("%0t: fraction expected %h, actual %h", $time, e.fraction, f);
				errors++;
			end
			if (p !== e.picked) begin
				$display("%0t: picked expected %h, actual %h", $time, e.picked, p);
				errors++;
			end
			if (r !== e.restarted) begin
				$display("%0t: restarted expected %b, actual %b", $time, e.restarted, r);
				errors++;
			end
		endfunction
	endclass

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               seed_write   = 1'b0;
	logic signed [31:0] seed_value   = '0;
	logic               item_valid   = 1'b0;
	logic               item_stall;
	logic               opcode       = 1'b0;
	logic [31:0]        range_limit  = '0;
	logic               result_valid;
	logic               result_stall = 1'b0;
	logic [31:0]        fraction;
	logic [31:0]        picked;
	logic               restarted;

	draw_ledger  ledger;
	bit          offering     = 1'b0;
	int unsigned burst_left   = 1;
	int unsigned results_seen = 0;
	word_t       seed_corners [8] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000,
		32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0002, 32'h8000_0001, 32'hFFFF_FFFE};

	subtractive_lagged_fibonacci_rng_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.seed_write   (seed_write),
		.seed_value   (seed_value),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.opcode       (opcode),
		.range_limit  (range_limit),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.fraction     (fraction),
		.picked       (picked),
		.restarted    (restarted)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic send_word(slfr_op_t op, word_t n);
		item_valid <= 1'b1;
		offering = 1'b1;
		opcode <= op;
		range_limit <= n;
		do @(posedge clk); while (item_stall);
		ledger.take_word(op, n);
		burst_left--;
		if (burst_left == 0) begin
			item_valid <= 1'b0;
			offering = 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 40);
		end
	endtask

	task automatic write_seed(word_t v);
		if (offering) begin
			item_valid <= 1'b0;
			offering = 1'b0;
		end
		while (ledger.pending() != 0) @(posedge clk);
		@(posedge clk);
		seed_write <= 1'b1;
		seed_value <= v;
		ledger.load_seed(v);
		@(posedge clk);
		seed_write <= 1'b0;
	endtask

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			ledger.match_word(fraction, picked, restarted);
			results_seen++;
		end
	end

	// stall receiver: quiet, light or heavy stretches, and one long hold
	initial begin
		int unsigned span;
		int unsigned pct;
		bit          held;
		held = 1'b0;
		@(posedge clk);
		forever begin
			if (!held && results_seen >= 60) begin
				held = 1'b1;
				result_stall <= 1'b1;
				repeat (300) @(posedge clk);
			end
			span = $urandom_range(5, 60);
			case ($urandom_range(0, 2))
				0: pct = 0;
				1: pct = 30;
				default: pct = 70;
			endcase
			repeat (span) begin
				result_stall <= ($urandom_range(1, 100) <= pct);
				@(posedge clk);
			end
		end
	end

	initial begin
		#40_000_000;
		$display("subtractive_lagged_fibonacci_rng_unit_test NOT OK");
		$finish;
	end

	initial begin
		word_t lim;
		ledger = new();
		burst_left = $urandom_range(1, 40);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(OP_DRAW, 32'd0);
		send_word(OP_DRAW, 32'd1);
		send_word(OP_DRAW, 32'hFFFF_FFFF);
		send_word(OP_DRAW, 32'h8000_0000);
		send_word(OP_DRAW, 32'd2);
		send_word(OP_DRAW, 32'hAAAA_AAAA);
		send_word(OP_DRAW, 32'h5555_5555);
		send_word(OP_RESTART, 32'hFFFF_FFFF);
		send_word(OP_DRAW, $urandom);
		for (int k = 0; k < 6; k++) begin
			write_seed(seed_corners[k]);
			send_word(OP_RESTART, 32'd0);
			send_word(OP_DRAW, $urandom);
		end

		for (int ph = 0; ph < 10; ph++) begin
			write_seed(($urandom_range(0, 9) < 4) ? seed_corners[$urandom_range(0, 7)] :
				$urandom);
			send_word(OP_RESTART, $urandom);
			repeat (127) begin
				case ($urandom_range(0, 9))
					0: lim = 32'd0;
					1: lim = 32'd1;
					2: lim = 32'hFFFF_FFFF;
					3: lim = $urandom_range(2, 16);
					default: lim = $urandom;
				endcase
				send_word(($urandom_range(0, 99) == 0) ? OP_RESTART : OP_DRAW, lim);
			end
		end

		if (offering)
			item_valid <= 1'b0;
		while (ledger.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (ledger.errors == 0 && ledger.pending() == 0)
			$display("subtractive_lagged_fibonacci_rng_unit_test OK");
		else
			$display("subtractive_lagged_fibonacci_rng_unit_test NOT OK");
		$finish;
	end

endmodule

// ===== subtractive_lagged_fibonacci_rng_unit.f =====
rtl/slfr_pkg.sv
rtl/slfr_cell.sv
rtl/slfr_chain.sv
rtl/slfr_recip.sv
rtl/subtractive_lagged_fibonacci_rng_unit.sv
rtl/slfr_checker.sv
dv/subtractive_lagged_fibonacci_rng_unit_test.sv
